// ===== rtl/sjc_pkg.sv =====
// ----------------------------------------------------------------------------
// sjc_pkg
// Shared types, constants, the 3x3 neighbour classification function and
// the height clamp for the skeleton junction classifier.
// ----------------------------------------------------------------------------
package sjc_pkg;

  // field widths
  localparam int PIX_W     = 8;
  localparam int CLS_W     = 3;
  localparam int POS_W     = 11;
  localparam int ROW_W     = 11;
  localparam int CNT_W     = 22;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;

  // pixel value that marks a skeleton pixel
  localparam logic [PIX_W-1:0] SET_VALUE = 8'hFF;

  // saturation limit of the branch count
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // image size limits and reset sizes
  localparam int DEF_MAX_WIDTH = 2048;
  localparam int HEIGHT_MAX    = 2048;
  localparam int MIN_DIM       = 3;
  localparam int WIDTH_RESET   = 640;
  localparam int HEIGHT_RESET  = 480;

  // neighbour ring
  localparam int NB_N      = 8;
  localparam int SUM_W     = $clog2(NB_N + 1);
  localparam int ON_COUNT  = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // result classes
  typedef enum logic [CLS_W-1:0] {
    CLS_END    = 3'd0,
    CLS_BRANCH = 3'd1,
    CLS_OTHER  = 3'd2,
    CLS_PLAIN  = 3'd3,
    CLS_TOTAL  = 3'd4
  } sjc_class_t;

  // one result as it sits in the output queue
  typedef struct packed {
    sjc_class_t       cls;
    logic [POS_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [CNT_W-1:0] total;
    logic             last;
  } sjc_result_t;

  // classify a set center from its ring, nb[1] above, clockwise to nb[8]
  function automatic sjc_class_t sjc_classify(input logic [NB_N:1] nb);
    logic [SUM_W-1:0] sum;
    logic             pair;
    sum = '0;
    for (int k = 1; k <= NB_N; k++) begin
      sum = sum + SUM_W'(nb[k]);
    end
    // adjacent ring pairs 1-2 .. 7-8, no wrap pair
    pair = |(nb[NB_N-1:1] & nb[NB_N:2]);
    if (sum < SUM_W'(ON_COUNT)) begin
      return CLS_END;
    end else if (sum > SUM_W'(ON_COUNT)) begin
      return CLS_BRANCH;
    end else if (pair) begin
      return CLS_OTHER;
    end
    return CLS_PLAIN;
  endfunction

  // last row index from the height register, clamped to the legal range
  function automatic logic [ROW_W-1:0] sjc_height_last(input logic [CFG_W-1:0] v);
    if (v < CFG_W'(MIN_DIM)) begin
      return ROW_W'(MIN_DIM - 1);
    end else if (v > CFG_W'(HEIGHT_MAX)) begin
      return ROW_W'(HEIGHT_MAX - 1);
    end
    return ROW_W'(v - CFG_W'(1));
  endfunction

endpackage

// ===== rtl/sjc_line_mem.sv =====
// ----------------------------------------------------------------------------
// sjc_line_mem
// Two-bit-wide line memory: one column of the upper and center rows per
// entry. One write port, one registered read port.
// ----------------------------------------------------------------------------
module sjc_line_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [1:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [1:0]    rd_data
);

  logic [1:0] mem [DEPTH];
  logic [1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/sjc_out_fifo.sv =====
// ----------------------------------------------------------------------------
// sjc_out_fifo
// Two-entry result queue. Takes up to two results per cycle, hands out one
// per cycle while out_stall is low, and reports room left after the pop.
// ----------------------------------------------------------------------------
module sjc_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_a,
  input  sjc_pkg::sjc_result_t data_a,
  input  logic                push_b,
  input  sjc_pkg::sjc_result_t data_b,
  output logic [1:0]          free,
  output logic                out_valid,
  input  logic                out_stall,
  output sjc_pkg::sjc_result_t out_data
);

  import sjc_pkg::*;

  sjc_result_t q_r   [2];
  sjc_result_t q_nxt [2];
  logic [1:0]  cnt_r;
  logic [1:0]  cnt_nxt;
  logic [1:0]  cnt_pop;
  logic [1:0]  wr_idx;
  logic        pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = q_r[0];
  assign pop       = out_valid && !out_stall;
  assign cnt_pop   = cnt_r - {1'b0, pop};
  assign free      = 2'd2 - cnt_pop;

  // shift on pop, then append new results behind what is left
  always_comb begin
    q_nxt[0] = q_r[0];
    q_nxt[1] = q_r[1];
    if (pop) begin
      q_nxt[0] = q_r[1];
    end
    wr_idx = cnt_pop;
    if (push_a) begin
      q_nxt[wr_idx[0]] = data_a;
      wr_idx = wr_idx + 2'd1;
    end
    if (push_b) begin
      q_nxt[wr_idx[0]] = data_b;
      wr_idx = wr_idx + 2'd1;
    end
    cnt_nxt = wr_idx;
  end

  // fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // entries
  always_ff @(posedge clk) begin
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
  end

endmodule

// ===== rtl/skeleton_junction_classifier.sv =====
// ----------------------------------------------------------------------------
// skeleton_junction_classifier
// 3x3 end / branch point detection on a binary skeleton pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter on the in_ channel in raster order, one byte per request;
// only 255 counts as a skeleton pixel. Each set interior pixel yields one
// request on the out_ channel with its class, position and the running
// branch count of the frame; a branch pixel is cleared, so later windows
// see it as zero. The last pixel of a frame adds one total request with
// out_frame_last set. The cfg_ channel writes image width (index 0) and
// height (index 1); a write to either restarts the frame, and is always
// taken. Throughput is one pixel per clock while the queue has room: the
// window is evaluated between the input stage register and a two-entry
// result queue, and the line memory is read once and written once per
// pixel. The frame-end pixel produces up to two requests and may hold the
// input. While out_stall is high results wait in the queue; once the
// input stage holds a pixel whose results do not fit, in_stall rises.
// Reset empties the queue and the stage and restarts at row 0, column 0;
// no memory clearing is needed, since rows 0 and 1 of every frame refill
// the lines before they are read.
// ----------------------------------------------------------------------------
module skeleton_junction_classifier #(
  parameter int MAX_WIDTH = sjc_pkg::DEF_MAX_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sjc_pkg::PIX_W-1:0]     in_pixel,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sjc_pkg::CLS_W-1:0]     out_pixel_class,
  output logic [sjc_pkg::POS_W-1:0]     out_col_pos,
  output logic [sjc_pkg::ROW_W-1:0]     out_row_pos,
  output logic [sjc_pkg::CNT_W-1:0]     out_branch_total,
  output logic                          out_frame_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sjc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sjc_pkg::CFG_W-1:0]     cfg_data
);

  import sjc_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WIDTH_RST_EFF = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
  localparam logic [CW-1:0]    W_LAST_RST = CW'(WIDTH_RST_EFF - 1);
  localparam logic [ROW_W-1:0] H_LAST_RST = ROW_W'(HEIGHT_RESET - 1);

  // configuration
  logic [CW-1:0]    w_last_r, w_last_nxt, w_last_cfg;
  logic [ROW_W-1:0] h_last_r, h_last_nxt;
  logic             cfg_wr;

  // input position
  logic [CW-1:0]    in_col_r, in_col_nxt;
  logic [ROW_W-1:0] in_row_r, in_row_nxt;
  logic             accept;

  // input stage
  logic             st_v_r, st_v_nxt;
  logic             st_pix_r;
  logic [CW-1:0]    st_col_r;
  logic [ROW_W-1:0] st_row_r;

  // window columns: u0/c0 two columns back, u1/c1 one back (the center)
  logic u0_r, u1_r, c0_r, c1_r, lm1_r, lm2_r;
  logic [1:0] rd_data;
  logic       rd_u, rd_c;

  // evaluation
  logic [NB_N:1]    nb;
  sjc_class_t       cls;
  logic             is_center, is_branch, frame_end, c1_clr, process;
  logic [1:0]       need, free;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [CW-1:0]    wr_addr;
  sjc_result_t      res_a, res_b, out_data;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // width register clamped at write time
  always_comb begin
    if (cfg_data < CFG_W'(MIN_DIM)) begin
      w_last_cfg = CW'(MIN_DIM - 1);
    end else if (32'(cfg_data) > MAX_WIDTH) begin
      w_last_cfg = CW'(MAX_WIDTH - 1);
    end else begin
      w_last_cfg = CW'(cfg_data - CFG_W'(1));
    end
  end

  // register writes
  always_comb begin
    w_last_nxt = w_last_r;
    h_last_nxt = h_last_r;
    if (cfg_wr && cfg_index == REG_IMAGE_WIDTH) begin
      w_last_nxt = w_last_cfg;
    end
    if (cfg_wr && cfg_index == REG_IMAGE_HEIGHT) begin
      h_last_nxt = sjc_height_last(cfg_data);
    end
  end

  // input handshake
  assign in_stall = st_v_r && !process;
  assign accept   = in_valid && !in_stall;

  // raster position of the next pixel
  always_comb begin
    in_col_nxt = in_col_r;
    in_row_nxt = in_row_r;
    if (cfg_wr && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT)) begin
      in_col_nxt = '0;
      in_row_nxt = '0;
    end else if (accept) begin
      if (in_col_r == w_last_r) begin
        in_col_nxt = '0;
        in_row_nxt = (in_row_r == h_last_r) ? '0 : in_row_r + ROW_W'(1);
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
    end
  end

  // line memory, read at accept, written as each column leaves the window
  sjc_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_mem (
    .clk     (clk),
    .wr_en   (process),
    .wr_addr (wr_addr),
    .wr_data ({c1_clr, lm1_r}),
    .rd_en   (accept),
    .rd_addr (in_col_r),
    .rd_data (rd_data)
  );

  assign rd_u = rd_data[1];
  assign rd_c = rd_data[0];

  // 3x3 window and classification
  assign nb        = {u0_r, c0_r, lm2_r, lm1_r, st_pix_r, rd_c, rd_u, u1_r};
  assign cls       = sjc_classify(nb);
  assign is_center = (st_row_r >= ROW_W'(2)) && (st_col_r >= CW'(2)) && c1_r;
  assign is_branch = is_center && (cls == CLS_BRANCH);
  assign frame_end = (st_col_r == w_last_r) && (st_row_r == h_last_r);
  assign c1_clr    = c1_r && !is_branch;
  assign cnt_inc   = (is_branch && cnt_r != CNT_MAX) ? cnt_r + CNT_W'(1) : cnt_r;

  // column 0 flushes the last column of the row before
  assign wr_addr = (st_col_r == '0) ? w_last_r : st_col_r - CW'(1);

  // results of the stage item
  always_comb begin
    res_a.cls   = cls;
    res_a.col   = POS_W'(st_col_r - CW'(1));
    res_a.row   = st_row_r - ROW_W'(1);
    res_a.total = cnt_inc;
    res_a.last  = 1'b0;
    res_b.cls   = CLS_TOTAL;
    res_b.col   = '0;
    res_b.row   = '0;
    res_b.total = cnt_inc;
    res_b.last  = 1'b1;
  end

  assign need    = {1'b0, is_center} + {1'b0, frame_end};
  assign process = st_v_r && (need <= free);

  // branch count
  always_comb begin
    cnt_nxt = cnt_r;
    if (cfg_wr && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT)) begin
      cnt_nxt = '0;
    end else if (process) begin
      cnt_nxt = frame_end ? '0 : cnt_inc;
    end
  end

  assign st_v_nxt = accept || (st_v_r && !process);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_last_r <= W_LAST_RST;
      h_last_r <= H_LAST_RST;
      in_col_r <= '0;
      in_row_r <= '0;
      st_v_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      w_last_r <= w_last_nxt;
      h_last_r <= h_last_nxt;
      in_col_r <= in_col_nxt;
      in_row_r <= in_row_nxt;
      st_v_r   <= st_v_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // input stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      st_pix_r <= (in_pixel == SET_VALUE);
      st_col_r <= in_col_r;
      st_row_r <= in_row_r;
    end
  end

  // window shift
  always_ff @(posedge clk) begin
    if (process) begin
      u0_r  <= u1_r;
      u1_r  <= rd_u;
      c0_r  <= c1_clr;
      c1_r  <= rd_c;
      lm2_r <= lm1_r;
      lm1_r <= st_pix_r;
    end
  end

  // result queue
  sjc_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_a    (process && is_center),
    .data_a    (res_a),
    .push_b    (process && frame_end),
    .data_b    (res_b),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_pixel_class  = out_data.cls;
  assign out_col_pos      = out_data.col;
  assign out_row_pos      = out_data.row;
  assign out_branch_total = out_data.total;
  assign out_frame_last   = out_data.last;

endmodule

// ===== rtl/sjc_checker.sv =====
// ----------------------------------------------------------------------------
// sjc_port_props
// Port-level checks on the result channel of the skeleton junction
// classifier, bound to the top level.
// ----------------------------------------------------------------------------
module sjc_port_props (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [sjc_pkg::CLS_W-1:0] out_pixel_class,
  input logic [sjc_pkg::POS_W-1:0] out_col_pos,
  input logic [sjc_pkg::ROW_W-1:0] out_row_pos,
  input logic [sjc_pkg::CNT_W-1:0] out_branch_total,
  input logic                      out_frame_last
);

  import sjc_pkg::*;

  // frame total carries the total class and a zero position
  a_total_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_last |->
      out_pixel_class == CLS_TOTAL && out_col_pos == '0 && out_row_pos == '0)
    else $error("frame total with wrong class or position");

  // pixel results never use the total class
  a_pixel_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_last |-> out_pixel_class <= CLS_PLAIN)
    else $error("pixel result with total or unknown class");

  // a branch result includes itself in the count
  a_branch_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pixel_class == CLS_BRANCH |-> out_branch_total != '0)
    else $error("branch result with zero branch count");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable({out_pixel_class, out_col_pos,
      out_row_pos, out_branch_total, out_frame_last}))
    else $error("stalled result changed or dropped");

  // reset empties the result queue
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind skeleton_junction_classifier sjc_port_props u_sjc_port_props (.*);
